// ===== rtl/nse_pkg.sv =====
// ----------------------------------------------------------------------------
// nse_pkg
// Shared types, constants and lookup functions for the NMEA field extractor.
// ----------------------------------------------------------------------------
package nse_pkg;

    localparam int unsigned MAX_SENTENCE_LEN = 128;
    localparam int unsigned CNT_W            = 8;
    localparam int unsigned HDR_LEN          = 5;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [1:0] KIND_GGA = 2'd0;
    localparam logic [1:0] KIND_VTG = 2'd1;
    localparam logic [1:0] KIND_ZDA = 2'd2;

    typedef struct packed {
        logic [1:0] sentence_kind;
        logic [2:0] field_slot;
        logic [3:0] char_pos;
        logic [7:0] char_code;
        logic       sentence_end;
    } t_result;

    // expected header character of kind k at header position p
    function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        unique case (p)
            3'd0: c = "G";
            3'd1: c = "P";
            3'd2: begin
                case (k)
                    KIND_GGA: c = "G";
                    KIND_VTG: c = "V";
                    default:  c = "Z";
                endcase
            end
            3'd3: begin
                case (k)
                    KIND_GGA: c = "G";
                    KIND_VTG: c = "T";
                    default:  c = "D";
                endcase
            end
            3'd4: begin
                case (k)
                    KIND_VTG: c = "G";
                    default:  c = "A";
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // slot + 1 for an NMEA field position, 0 when not wanted
    function automatic logic [2:0] slot_map(input logic [1:0] k, input logic [3:0] f);
        logic [2:0] s;
        s = 3'd0;
        unique case (k)
            KIND_GGA: if (f >= 4'd1 && f <= 4'd5) s = f[2:0];
            KIND_VTG: begin
                case (f)
                    4'd1:    s = 3'd1;
                    4'd3:    s = 3'd2;
                    4'd7:    s = 3'd3;
                    default: s = 3'd0;
                endcase
            end
            KIND_ZDA: if (f >= 4'd1 && f <= 4'd4) s = f[2:0];
            default:  s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] slot_width(input logic [1:0] k, input logic [2:0] s);
        logic [3:0] w;
        w = 4'd0;
        unique case (k)
            KIND_GGA: begin
                case (s)
                    3'd0:    w = 4'd6;
                    3'd1:    w = 4'd8;
                    3'd2:    w = 4'd1;
                    3'd3:    w = 4'd9;
                    3'd4:    w = 4'd1;
                    default: w = 4'd0;
                endcase
            end
            KIND_VTG: w = (s <= 3'd2) ? 4'd5 : 4'd0;
            KIND_ZDA: begin
                case (s)
                    3'd0:    w = 4'd6;
                    3'd1:    w = 4'd2;
                    3'd2:    w = 4'd2;
                    3'd3:    w = 4'd4;
                    default: w = 4'd0;
                endcase
            end
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/nse_front.sv =====
// ----------------------------------------------------------------------------
// nse_front
// Byte classifier: tracks sentence, header and field position and pushes
// one result per wanted character or closing CR into the queue.
// ----------------------------------------------------------------------------
module nse_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_room,
    output logic             o_push,
    output nse_pkg::t_result o_result
);

    logic                      r_in_sentence, n_in_sentence;
    logic [nse_pkg::CNT_W-1:0] r_byte_count,  n_byte_count;
    logic [2:0]                r_hdr_match,   n_hdr_match;
    logic [1:0]                r_kind,        n_kind;
    logic [3:0]                r_field_idx,   n_field_idx;
    logic [3:0]                r_char_idx,    n_char_idx;

    logic       accept;
    logic [2:0] slot_p1;
    logic [2:0] slot;

    assign o_ready = i_room;
    assign accept  = i_valid & i_room;
    assign slot_p1 = nse_pkg::slot_map(r_kind, r_field_idx);
    assign slot    = slot_p1 - 3'd1;

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_byte_count  = r_byte_count;
        n_hdr_match   = r_hdr_match;
        n_kind        = r_kind;
        n_field_idx   = r_field_idx;
        n_char_idx    = r_char_idx;
        o_push        = 1'b0;
        o_result      = '0;
        if (accept) begin
            if (i_rx_byte == nse_pkg::CH_START) begin
                n_in_sentence = 1'b1;
                n_byte_count  = '0;
                n_hdr_match   = 3'b111;
                n_kind        = nse_pkg::KIND_GGA;
                n_field_idx   = '0;
                n_char_idx    = '0;
            end else if (r_in_sentence) begin
                if (i_rx_byte == nse_pkg::CH_CR) begin
                    n_in_sentence = 1'b0;
                    if (r_byte_count >= nse_pkg::CNT_W'(nse_pkg::HDR_LEN)
                        && r_hdr_match != 3'b000) begin
                        o_push                 = 1'b1;
                        o_result.sentence_kind = r_kind;
                        o_result.sentence_end  = 1'b1;
                    end
                end else if (r_byte_count < nse_pkg::CNT_W'(nse_pkg::MAX_SENTENCE_LEN)) begin
                    n_byte_count = r_byte_count + 1'b1;
                    if (r_byte_count < nse_pkg::CNT_W'(nse_pkg::HDR_LEN)) begin
                        for (int k = 0; k < 3; k++) begin
                            if (i_rx_byte != nse_pkg::hdr_char(2'(k), r_byte_count[2:0]))
                                n_hdr_match[k] = 1'b0;
                        end
                        if (r_byte_count == nse_pkg::CNT_W'(nse_pkg::HDR_LEN - 1)) begin
                            if (n_hdr_match[0])
                                n_kind = nse_pkg::KIND_GGA;
                            else if (n_hdr_match[1])
                                n_kind = nse_pkg::KIND_VTG;
                            else if (n_hdr_match[2])
                                n_kind = nse_pkg::KIND_ZDA;
                        end
                    end else if (r_hdr_match != 3'b000) begin
                        if (i_rx_byte == nse_pkg::CH_COMMA) begin
                            if (r_field_idx != 4'hF)
                                n_field_idx = r_field_idx + 1'b1;
                            n_char_idx = '0;
                        end else if (slot_p1 != 3'd0) begin
                            if (r_char_idx != 4'hF)
                                n_char_idx = r_char_idx + 1'b1;
                            if (r_char_idx < nse_pkg::slot_width(r_kind, slot)) begin
                                o_push                 = 1'b1;
                                o_result.sentence_kind = r_kind;
                                o_result.field_slot    = slot;
                                o_result.char_pos      = r_char_idx;
                                o_result.char_code     = i_rx_byte;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_byte_count  <= '0;
            r_hdr_match   <= 3'b111;
            r_kind        <= nse_pkg::KIND_GGA;
            r_field_idx   <= '0;
            r_char_idx    <= '0;
        end else begin
            r_in_sentence <= n_in_sentence;
            r_byte_count  <= n_byte_count;
            r_hdr_match   <= n_hdr_match;
            r_kind        <= n_kind;
            r_field_idx   <= n_field_idx;
            r_char_idx    <= n_char_idx;
        end
    end

    // a push only ever comes from an accepted byte inside a sentence
    a_push_in_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (accept && r_in_sentence))
        else $error("push outside sentence");

    // CR always leaves the sentence
    a_cr_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx_byte == nse_pkg::CH_CR) |=> !r_in_sentence)
        else $error("CR did not end sentence");

    // byte count never passes the sentence limit
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= nse_pkg::CNT_W'(nse_pkg::MAX_SENTENCE_LEN))
        else $error("byte count overflow");

endmodule

// ===== rtl/nse_queue.sv =====
// ----------------------------------------------------------------------------
// nse_queue
// Two-entry result queue; its head drives the output channel directly.
// ----------------------------------------------------------------------------
module nse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nse_pkg::t_result i_result,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output nse_pkg::t_result o_result
);

    nse_pkg::t_result r_mem [nse_pkg::QUEUE_DEPTH];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count,  n_count;
    logic             pop;

    assign o_room   = (r_count != 2'(nse_pkg::QUEUE_DEPTH));
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid & i_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop    ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'(nse_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(nse_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'(nse_pkg::QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/nmea_sentence_field_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_field_extractor_unit
// NMEA 0183 sentence parser emitting wanted field characters of GGA/VTG/ZDA.
//
// Input channel (i_valid / o_ready / i_rx_byte): one received serial byte
// per transaction. Output channel (o_valid / i_ready / o_*): one extracted
// character, or an end marker when CR closes a recognized sentence.
// Bytes that produce nothing are consumed without an output transaction.
// Throughput: one byte per cycle, sustained while the receiver takes
// results. A two-entry queue between the classifier and the output presents
// a result the cycle after its byte is accepted, unless an older one waits.
// When the receiver stalls, the queue fills; o_ready drops only while both
// entries are held, so the classifier keeps taking bytes until then.
// Reset (synchronous, active low) leaves the sentence, clears the header
// match to all candidates and empties the queue; the block is ready on the
// first cycle after reset.
// ----------------------------------------------------------------------------
module nmea_sentence_field_extractor_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_sentence_kind,
    output logic [2:0] o_field_slot,
    output logic [3:0] o_char_pos,
    output logic [7:0] o_char_code,
    output logic       o_sentence_end
);

    logic             room;
    logic             push;
    nse_pkg::t_result push_result;
    nse_pkg::t_result head;

    nse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_room    (room),
        .o_push    (push),
        .o_result  (push_result)
    );

    nse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (push_result),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (head)
    );

    assign o_sentence_kind = head.sentence_kind;
    assign o_field_slot    = head.field_slot;
    assign o_char_pos      = head.char_pos;
    assign o_char_code     = head.char_code;
    assign o_sentence_end  = head.sentence_end;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the NMEA field extractor against a cycle-free model of its parser.
// Directed bytes first, then random GGA/VTG/ZDA sentences mixed with broken
// headers, cut and overlong sentences and line noise, under random input
// bursts and output stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_AT     = 900;
    localparam int HOLD_LEN    = 400;
    localparam int ITEM_GOAL   = 1900;

    function automatic string sentence_tag(input int k);
        case (k)
            0:       return "GPGGA";
            1:       return "GPVTG";
            default: return "GPZDA";
        endcase
    endfunction

    class field_char_board;
        nse_pkg::t_result due_chars[$];
        int unsigned      n_chars;
        int unsigned      n_ends;
        int unsigned      n_bad;
        bit               in_sent;
        int unsigned      n_after_start;
        logic [2:0]       cand;
        logic [1:0]       kind;
        logic [3:0]       field_no;
        logic [3:0]       char_no;

        function new();
            n_chars       = 0;
            n_ends        = 0;
            n_bad         = 0;
            in_sent       = 1'b0;
            n_after_start = 0;
            cand          = 3'b111;
            kind          = nse_pkg::KIND_GGA;
            field_no      = '0;
            char_no       = '0;
        endfunction

        // slot of an NMEA field position, -1 when the field is not captured
        function int wanted_slot(input logic [1:0] k, input logic [3:0] f);
            case (k)
                nse_pkg::KIND_GGA: return (f >= 1 && f <= 5) ? int'(f) - 1 : -1;
                nse_pkg::KIND_VTG: begin
                    case (f)
                        4'd1:    return 0;
                        4'd3:    return 1;
                        4'd7:    return 2;
                        default: return -1;
                    endcase
                end
                nse_pkg::KIND_ZDA: return (f >= 1 && f <= 4) ? int'(f) - 1 : -1;
                default:           return -1;
            endcase
        endfunction

        function int slot_chars(input logic [1:0] k, input int s);
            case (k)
                nse_pkg::KIND_GGA: begin
                    case (s)
                        0:       return 6;
                        1:       return 8;
                        3:       return 9;
                        default: return 1;
                    endcase
                end
                nse_pkg::KIND_VTG: return 5;
                default: begin
                    case (s)
                        0:       return 6;
                        3:       return 4;
                        default: return 2;
                    endcase
                end
            endcase
        endfunction

        function bit parse_byte(input logic [7:0] b, output nse_pkg::t_result r);
            int pos;
            int slot;
            int ci;
            string tag;
            r = '0;
            if (b == nse_pkg::CH_START) begin
                in_sent       = 1'b1;
                n_after_start = 0;
                cand          = 3'b111;
                kind          = nse_pkg::KIND_GGA;
                field_no      = '0;
                char_no       = '0;
                return 1'b0;
            end
            if (!in_sent) return 1'b0;
            if (b == nse_pkg::CH_CR) begin
                in_sent = 1'b0;
                if (n_after_start >= nse_pkg::HDR_LEN && cand != 3'b000) begin
                    r.sentence_kind = kind;
                    r.sentence_end  = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (n_after_start >= nse_pkg::MAX_SENTENCE_LEN) return 1'b0;
            pos = n_after_start;
            n_after_start++;
            if (pos < nse_pkg::HDR_LEN) begin
                for (int k = 0; k < 3; k++) begin
                    tag = sentence_tag(k);
                    if (b != tag[pos]) cand[k] = 1'b0;
                end
                if (pos == nse_pkg::HDR_LEN - 1) begin
                    if (cand[0])      kind = nse_pkg::KIND_GGA;
                    else if (cand[1]) kind = nse_pkg::KIND_VTG;
                    else if (cand[2]) kind = nse_pkg::KIND_ZDA;
                end
                return 1'b0;
            end
            if (cand == 3'b000) return 1'b0;
            if (b == nse_pkg::CH_COMMA) begin
                if (field_no != 4'd15) field_no++;
                char_no = '0;
                return 1'b0;
            end
            slot = wanted_slot(kind, field_no);
            if (slot < 0) return 1'b0;
            ci = char_no;
            if (char_no != 4'd15) char_no++;
            if (ci >= slot_chars(kind, slot)) return 1'b0;
            r.sentence_kind = kind;
            r.field_slot    = 3'(slot);
            r.char_pos      = 4'(ci);
            r.char_code     = b;
            return 1'b1;
        endfunction

        function void take_byte(input logic [7:0] b);
            nse_pkg::t_result r;
            if (parse_byte(b, r)) due_chars.push_back(r);
        endfunction

        function void match_char(input nse_pkg::t_result got);
            nse_pkg::t_result want;
            if (due_chars.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: kind=%0d slot=%0d pos=%0d code=%02h end=%0b",
                             got.sentence_kind, got.field_slot, got.char_pos,
                             got.char_code, got.sentence_end);
                return;
            end
            want = due_chars.pop_front();
            if (got !== want) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("mismatch: expected kind=%0d slot=%0d pos=%0d code=%02h end=%0b",
                             want.sentence_kind, want.field_slot, want.char_pos,
                             want.char_code, want.sentence_end);
                    $display("          actual   kind=%0d slot=%0d pos=%0d code=%02h end=%0b",
                             got.sentence_kind, got.field_slot, got.char_pos,
                             got.char_code, got.sentence_end);
                end
            end else if (want.sentence_end) begin
                n_ends++;
            end else begin
                n_chars++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_sentence_kind;
    logic [2:0] o_field_slot;
    logic [3:0] o_char_pos;
    logic [7:0] o_char_code;
    logic       o_sentence_end;

    field_char_board board;
    logic [7:0]      tx_q[$];
    int              sent_bytes;
    int              burst_left;
    int              n_good[3];
    int              n_odd;
    bit              draining;

    nmea_sentence_field_extractor_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sentence_kind (o_sentence_kind),
        .o_field_slot    (o_field_slot),
        .o_char_pos      (o_char_pos),
        .o_char_code     (o_char_code),
        .o_sentence_end  (o_sentence_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        board.take_byte(b);
        sent_bytes++;
    endtask

    task automatic flush_tx();
        while (tx_q.size() != 0) send_byte(tx_q.pop_front());
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == nse_pkg::CH_START || c == nse_pkg::CH_CR
               || c == nse_pkg::CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] field_char();
        string letters;
        int    r;
        letters = "NSEWMKT";
        r = $urandom_range(0, 9);
        if (r < 7)  return 8'("0") + 8'($urandom_range(0, 9));
        if (r == 7) return 8'(".");
        if (r == 8) return letters[$urandom_range(0, 6)];
        return plain_byte();
    endfunction

    task automatic add_field();
        int r;
        int len;
        r = $urandom_range(0, 9);
        if (r == 0)      len = 0;
        else if (r < 8)  len = $urandom_range(1, 10);
        else             len = $urandom_range(11, 18);
        for (int i = 0; i < len; i++) tx_q.push_back(field_char());
    endtask

    task automatic make_sentence();
        int    mode;
        int    k;
        int    nfields;
        int    cut;
        int    pos;
        string tag;
        string hex;
        logic [7:0] c;
        hex  = "0123456789ABCDEF";
        mode = $urandom_range(0, 99);
        k    = $urandom_range(0, 2);
        tag  = sentence_tag(k);
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 4)) tx_q.push_back(8'($urandom_range(0, 255)));
        tx_q.push_back(nse_pkg::CH_START);
        if (mode < 70) begin
            n_good[k]++;
            push_text(tag);
            nfields = (k == 0) ? 14 : (k == 1) ? 9 : 6;
            if ($urandom_range(0, 5) == 0) nfields = $urandom_range(0, 20);
            for (int i = 0; i < nfields; i++) begin
                tx_q.push_back(nse_pkg::CH_COMMA);
                add_field();
            end
            if ($urandom_range(0, 1) == 1) begin
                tx_q.push_back(8'("*"));
                tx_q.push_back(hex[$urandom_range(0, 15)]);
                tx_q.push_back(hex[$urandom_range(0, 15)]);
            end
            tx_q.push_back(nse_pkg::CH_CR);
            if ($urandom_range(0, 1) == 1) tx_q.push_back(8'h0A);
        end else if (mode < 78) begin
            n_odd++;
            pos = $urandom_range(0, 4);
            for (int i = 0; i < 5; i++) begin
                if (i == pos) begin
                    do c = plain_byte(); while (c == tag[i]);
                    tx_q.push_back(c);
                end else begin
                    tx_q.push_back(tag[i]);
                end
            end
            repeat ($urandom_range(1, 8)) begin
                tx_q.push_back(nse_pkg::CH_COMMA);
                add_field();
            end
            tx_q.push_back(nse_pkg::CH_CR);
        end else if (mode < 84) begin
            n_odd++;
            cut = $urandom_range(0, 4);
            for (int i = 0; i < cut; i++) tx_q.push_back(tag[i]);
            tx_q.push_back(nse_pkg::CH_CR);
        end else if (mode < 92) begin
            // sentence broken off, the next start character restarts parsing
            n_odd++;
            push_text(tag);
            repeat ($urandom_range(0, 5)) begin
                tx_q.push_back(nse_pkg::CH_COMMA);
                add_field();
            end
        end else if (mode < 95) begin
            n_odd++;
            push_text(tag);
            repeat ($urandom_range(140, 170))
                tx_q.push_back(($urandom_range(0, 3) == 0) ? nse_pkg::CH_COMMA
                                                           : field_char());
            tx_q.push_back(nse_pkg::CH_CR);
        end else begin
            n_odd++;
            void'(tx_q.pop_back());
            repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
        end
        flush_tx();
    endtask

    // output side: random stall patterns plus one long hold-off
    initial begin
        nse_pkg::t_result got;
        int               mode;
        int               mode_left;
        int               hold_left;
        bit               held;
        logic [7:0]       pat;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        pat       = 8'hFF;
        i_ready  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.sentence_kind = o_sentence_kind;
                got.field_slot    = o_field_slot;
                got.char_pos      = o_char_pos;
                got.char_code     = o_char_code;
                got.sentence_end  = o_sentence_end;
                board.match_char(got);
            end
            if (draining) begin
                i_ready <= 1'b1;
            end else if (!held && sent_bytes >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
                i_ready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                    pat       = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 1) == 1);
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        i_ready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
            if (idle >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        board      = new();
        sent_bytes = 0;
        burst_left = 0;
        n_odd      = 0;
        draining   = 1'b0;
        for (int i = 0; i < 3; i++) n_good[i] = 0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes outside a sentence, a short ZDA, a header cut short
        tx_q.push_back(8'h00);
        tx_q.push_back(8'hFF);
        tx_q.push_back(nse_pkg::CH_CR);
        push_text("$GPZDA,1,22,333");
        tx_q.push_back(nse_pkg::CH_CR);
        push_text("$GPX");
        tx_q.push_back(nse_pkg::CH_CR);
        flush_tx();

        while (sent_bytes < ITEM_GOAL) make_sentence();

        i_valid  <= 1'b0;
        draining  = 1'b1;
        while (board.due_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d bytes: %0d GGA, %0d VTG, %0d ZDA sentences, %0d malformed or noise",
                 sent_bytes, n_good[0], n_good[1], n_good[2], n_odd);
        $display("checked %0d field characters and %0d end markers, %0d mismatches",
                 board.n_chars, board.n_ends, board.n_bad);
        if (board.n_bad == 0 && board.due_chars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nse_pkg.sv
rtl/nse_front.sv
rtl/nse_queue.sv
rtl/nmea_sentence_field_extractor_unit.sv
verif/testbench.sv
